// ----- src/des_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

	localparam int ROUNDS = 16;

	typedef logic [47:0] des_rkey_t;

	typedef struct packed {
		logic        func;
		logic [31:0] l;
		logic [31:0] r;
	} des_stage_t;

	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	localparam logic [2:0] ADDR_CIPHER_KEY = 3'd0;

	localparam logic [6:0] TAB_IP [64] = '{
		7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
		7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
		7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
		7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
		7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
		7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

	localparam logic [6:0] TAB_FP [64] = '{
		7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
		7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
		7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
		7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
		7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
		7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
		7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
		7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

	localparam logic [6:0] TAB_E [48] = '{
		7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd4,  7'd5,
		7'd6,  7'd7,  7'd8,  7'd9,  7'd8,  7'd9,  7'd10, 7'd11,
		7'd12, 7'd13, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
		7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd20, 7'd21,
		7'd22, 7'd23, 7'd24, 7'd25, 7'd24, 7'd25, 7'd26, 7'd27,
		7'd28, 7'd29, 7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1};

	localparam logic [6:0] TAB_P [32] = '{
		7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
		7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
		7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
		7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25};

	localparam logic [6:0] TAB_PC1 [56] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
		7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
		7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
		7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
		7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
		7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
		7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

	localparam logic [6:0] TAB_PC2 [48] = '{
		7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
		7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
		7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
		7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
		7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
		7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32};

	// total left rotation of c and d after each round: running sum of 1,1,2,2,2,2,2,2,1,2,...
	localparam logic [4:0] ROT_SUM [ROUNDS] = '{
		5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
		5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

	localparam logic [3:0] SBOX [8][64] = '{
		'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
		  4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
		  4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
		  4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
		  4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
		  4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
		  4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
		  4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
		'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
		  4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
		  4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
		  4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
		  4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
		  4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
		  4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
		  4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
		'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
		  4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
		  4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
		  4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
		  4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
		  4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
		  4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
		  4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
		'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
		  4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
		  4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
		  4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
		  4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
		  4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
		  4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
		  4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
		'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
		  4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
		  4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
		  4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
		  4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
		  4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
		  4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
		  4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
		'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
		  4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
		  4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
		  4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
		  4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
		  4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
		  4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
		  4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
		'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
		  4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
		  4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
		  4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
		  4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
		  4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
		  4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
		  4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
		'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
		  4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
		  4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
		  4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
		  4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
		  4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
		  4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
		  4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}};

	// tables count bits from 1 at the msb
	function automatic logic [63:0] perm_ip(input logic [63:0] v);
		logic [63:0] r;
		for (int k = 0; k < 64; k++) begin
			r[63-k] = v[64-int'(TAB_IP[k])];
		end
		return r;
	endfunction

	function automatic logic [63:0] perm_fp(input logic [63:0] v);
		logic [63:0] r;
		for (int k = 0; k < 64; k++) begin
			r[63-k] = v[64-int'(TAB_FP[k])];
		end
		return r;
	endfunction

	function automatic logic [47:0] perm_e(input logic [31:0] v);
		logic [47:0] r;
		for (int k = 0; k < 48; k++) begin
			r[47-k] = v[32-int'(TAB_E[k])];
		end
		return r;
	endfunction

	function automatic logic [31:0] perm_p(input logic [31:0] v);
		logic [31:0] r;
		for (int k = 0; k < 32; k++) begin
			r[31-k] = v[32-int'(TAB_P[k])];
		end
		return r;
	endfunction

	function automatic logic [55:0] perm_pc1(input logic [63:0] v);
		logic [55:0] r;
		for (int k = 0; k < 56; k++) begin
			r[55-k] = v[64-int'(TAB_PC1[k])];
		end
		return r;
	endfunction

	function automatic logic [47:0] perm_pc2(input logic [55:0] v);
		logic [47:0] r;
		for (int k = 0; k < 48; k++) begin
			r[47-k] = v[56-int'(TAB_PC2[k])];
		end
		return r;
	endfunction

	function automatic logic [27:0] rot28(input logic [27:0] v, input logic [4:0] s);
		logic [55:0] t;
		t = {v, v} << s;
		return t[55:28];
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input des_rkey_t rk);
		logic [47:0] x;
		logic [5:0]  six;
		logic [31:0] s;
		x = perm_e(r) ^ rk;
		for (int b = 0; b < 8; b++) begin
			six = x[47-6*b -: 6];
			s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
		end
		return perm_p(s);
	endfunction

endpackage

`default_nettype wire

// ----- src/des_block_cipher_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// DES block cipher, electronic codebook. Each beat on the slave side carries one 64-bit
// block in s_tdata (first byte in the most significant bits) and the direction in
// s_tuser (0 encrypt, 1 decrypt); the result leaves on the master side in the same order,
// from the last round register. The 16 Feistel rounds are unrolled into 16
// registered stages, one round each, so one block enters per cycle; a stalled master
// side holds the pipeline, while empty stages keep filling. The 64-bit key sits at APB
// address 0 and its parity bits are ignored; the round keys are wired from it, so the
// key must only change while no block is in flight.
module des_block_cipher_top
	import des_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // block_in
	input  wire logic        s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata    // block_out
);

	logic [63:0] cipher_key_q;
	des_rkey_t   round_key [ROUNDS];
	logic        vld [ROUNDS+1];
	logic        rdy [ROUNDS+1];
	des_stage_t  stg [ROUNDS+1];
	logic [63:0] blk_ip;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CIPHER_KEY) ? cipher_key_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= 64'd0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_CIPHER_KEY) begin
			cipher_key_q <= pwdata;
		end
	end

	des_key_sched u_key_sched (
		.cipher_key (cipher_key_q),
		.round_key  (round_key)
	);

	assign blk_ip      = perm_ip(s_tdata);
	assign stg[0].func = s_tuser;
	assign stg[0].l    = blk_ip[63:32];
	assign stg[0].r    = blk_ip[31:0];
	assign vld[0]      = s_tvalid;
	assign s_tready    = rdy[0];

	for (genvar i = 0; i < ROUNDS; i++) begin : g_round
		des_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_stage  (stg[i]),
			.key_enc   (round_key[i]),
			.key_dec   (round_key[ROUNDS-1-i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_stage (stg[i+1])
		);
	end

	// last stage is the output register; final swap and inverse ip are wiring
	assign rdy[ROUNDS] = m_tready;
	assign m_tvalid    = vld[ROUNDS];
	assign m_tdata     = perm_fp({stg[ROUNDS].r, stg[ROUNDS].l});

endmodule

`default_nettype wire

// ----- src/des_key_sched.sv -----
`timescale 1ns / 1ps
`default_nettype none

module des_key_sched
	import des_pkg::*;
(
	input  wire logic [63:0] cipher_key,
	output des_rkey_t        round_key [ROUNDS]
);

	logic [55:0] cd;
	logic [27:0] c_base;
	logic [27:0] d_base;

	assign cd     = perm_pc1(cipher_key);
	assign c_base = cd[55:28];
	assign d_base = cd[27:0];

	// each round key is pure wiring of the key register
	always_comb begin
		for (int i = 0; i < ROUNDS; i++) begin
			round_key[i] = perm_pc2({rot28(c_base, ROT_SUM[i]), rot28(d_base, ROT_SUM[i])});
		end
	end

endmodule

`default_nettype wire

// ----- src/des_round.sv -----
`timescale 1ns / 1ps
`default_nettype none

module des_round
	import des_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  des_stage_t      in_stage,
	input  des_rkey_t       key_enc,
	input  des_rkey_t       key_dec,
	output logic            out_valid,
	input  wire logic       out_ready,
	output des_stage_t      out_stage
);

	logic       valid_s1;
	des_stage_t stage_s1;
	des_rkey_t  rk;

	// an empty stage fills even while the next one is stalled
	assign in_ready  = !valid_s1 || out_ready;
	assign rk        = (in_stage.func == FUNC_DECRYPT) ? key_dec : key_enc;
	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			stage_s1.func <= in_stage.func;
			stage_s1.l    <= in_stage.r;
			stage_s1.r    <= in_stage.l ^ feistel(in_stage.r, rk);
		end
	end

endmodule

`default_nettype wire
